/* design/spct_pkg.sv */
// shared constants for the segment pair cutoff test
package spct_pkg;
  localparam int unsigned CutoffBits = 34;
  localparam int unsigned AddrBits = 1;
  localparam logic [AddrBits-1:0] RegCutoff = 1'b0;
endpackage

/* design/spct_vec.sv */
// endpoint differences and cross products, two register stages
module spct_vec #(
  parameter int unsigned CB = 16
) (
  input  logic clk_i,
  input  logic en_i,
  input  logic signed [CB-1:0] is_i [3],
  input  logic signed [CB-1:0] ie_i [3],
  input  logic signed [CB-1:0] js_i [3],
  input  logic signed [CB-1:0] je_i [3],
  output logic signed [CB:0] c_o [3],
  output logic signed [2*CB+2:0] n_o [3],
  output logic signed [2*CB+2:0] cb_o [3],
  output logic signed [2*CB+2:0] ca_o [3]
);
  logic signed [CB:0] a_q [3], b_q [3], c_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        a_q[k] <= (CB+1)'(ie_i[k]) - (CB+1)'(is_i[k]);
        b_q[k] <= (CB+1)'(je_i[k]) - (CB+1)'(js_i[k]);
        c_q[k] <= (CB+1)'(js_i[k]) - (CB+1)'(is_i[k]);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        c_o[k] <= c_q[k];
        n_o[k] <= (2*CB+3)'(a_q[(k+1)%3] * b_q[(k+2)%3])
                - (2*CB+3)'(a_q[(k+2)%3] * b_q[(k+1)%3]);
        cb_o[k] <= (2*CB+3)'(c_q[(k+1)%3] * b_q[(k+2)%3])
                 - (2*CB+3)'(c_q[(k+2)%3] * b_q[(k+1)%3]);
        ca_o[k] <= (2*CB+3)'(c_q[(k+1)%3] * a_q[(k+2)%3])
                 - (2*CB+3)'(c_q[(k+2)%3] * a_q[(k+1)%3]);
      end
    end
  end
endmodule

/* design/spct_dot.sv */
// dot products, final products and compares
module spct_dot
  import spct_pkg::*;
#(
  parameter int unsigned CB = 16
) (
  input  logic clk_i,
  input  logic en_i,
  input  logic [CutoffBits-1:0] cutoff_i,
  input  logic signed [CB:0] c_i [3],
  input  logic signed [2*CB+2:0] n_i [3],
  input  logic signed [2*CB+2:0] cb_i [3],
  input  logic signed [2*CB+2:0] ca_i [3],
  output logic hit_o
);
  localparam int unsigned PW = 4*CB+8;
  localparam int unsigned CW = 3*CB+6;
  localparam int unsigned HW = CW/2;
  localparam int unsigned GW = CW - HW;
  localparam int unsigned DLW = PW/2;
  localparam int unsigned DHW = PW - DLW;
  localparam int unsigned CLW = CutoffBits/2;
  localparam int unsigned CHW = CutoffBits - CLW;
  localparam int unsigned SW = (2*CW > CutoffBits+PW) ? 2*CW : CutoffBits+PW;
  logic signed [PW-1:0] d_q, ns_q, nt_q;
  logic signed [CW-1:0] cn_q;
  logic [CW-1:0] cn_mag;
  logic [2*GW-1:0] sq_hh_q;
  logic [GW+HW-1:0] sq_hl_q;
  logic [2*HW-1:0] sq_ll_q;
  logic [CHW+DHW-1:0] rc_hh_q;
  logic [CHW+DLW-1:0] rc_hl_q;
  logic [CLW+DHW-1:0] rc_lh_q;
  logic [CLW+DLW-1:0] rc_ll_q;
  logic [SW-1:0] lhs_q, rhs_q;
  logic pre_q, pre2_q;
  assign cn_mag = cn_q[CW-1] ? $unsigned(-cn_q) : $unsigned(cn_q);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= PW'(n_i[0]*n_i[0]) + PW'(n_i[1]*n_i[1]) + PW'(n_i[2]*n_i[2]);
      ns_q <= PW'(cb_i[0]*n_i[0]) + PW'(cb_i[1]*n_i[1]) + PW'(cb_i[2]*n_i[2]);
      nt_q <= PW'(ca_i[0]*n_i[0]) + PW'(ca_i[1]*n_i[1]) + PW'(ca_i[2]*n_i[2]);
      cn_q <= CW'(c_i[0]*n_i[0]) + CW'(c_i[1]*n_i[1]) + CW'(c_i[2]*n_i[2]);
      // split products of the squared distance and the scaled cutoff
      sq_hh_q <= cn_mag[CW-1:HW] * cn_mag[CW-1:HW];
      sq_hl_q <= cn_mag[CW-1:HW] * cn_mag[HW-1:0];
      sq_ll_q <= cn_mag[HW-1:0] * cn_mag[HW-1:0];
      rc_hh_q <= cutoff_i[CutoffBits-1:CLW] * d_q[PW-1:DLW];
      rc_hl_q <= cutoff_i[CutoffBits-1:CLW] * d_q[DLW-1:0];
      rc_lh_q <= cutoff_i[CLW-1:0] * d_q[PW-1:DLW];
      rc_ll_q <= cutoff_i[CLW-1:0] * d_q[DLW-1:0];
      pre_q <= (d_q != '0) && (ns_q >= 0) && (ns_q <= d_q) && (nt_q >= 0)
               && (nt_q <= d_q);
      lhs_q <= (SW'(sq_hh_q) << (2*HW)) + (SW'(sq_hl_q) << (HW+1)) + SW'(sq_ll_q);
      rhs_q <= (SW'(rc_hh_q) << (CLW+DLW)) + (SW'(rc_hl_q) << CLW)
               + (SW'(rc_lh_q) << DLW) + SW'(rc_ll_q);
      pre2_q <= pre_q;
      hit_o <= pre2_q && (lhs_q <= rhs_q);
    end
  end
endmodule

/* design/segment_pair_cutoff_test.sv */
// segment pair cutoff test top level
// throughput: one word per cycle; a stall freezes the whole pipeline
// reset: valid bits and cutoff_q clear to zero, data registers unreset
module segment_pair_cutoff_test
  import spct_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // i start xyz, i end xyz, j start xyz, j end xyz
  input  logic [((12*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // in_range
  output logic [7:0] m_axis_tdata_o,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [AddrBits+2:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic pready
);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned Depth = 6;
  logic [CutoffBits-1:0] cutoff_q;
  logic [Depth-1:0] vld_q;
  logic en;
  logic signed [CB-1:0] pt [4][3];
  logic signed [CB:0] c [3];
  logic signed [2*CB+2:0] n [3], cbv [3], cav [3];
  logic hit;
  assign pready = 1'b1;
  assign prdata = (paddr[AddrBits+2:3] == RegCutoff) ? 64'(cutoff_q) : '0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= '0;
    end else if (psel && penable && pwrite && paddr[AddrBits+2:3] == RegCutoff) begin
      cutoff_q <= pwdata[CutoffBits-1:0];
    end
  end
  assign en = !vld_q[Depth-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid_i};
    end
  end
  always_comb begin
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 3; k++) begin
        pt[p][k] = s_axis_tdata_i[(3*p+k)*CB +: CB];
      end
    end
  end
  spct_vec #(.CB(CB)) u_vec (
    .clk_i, .en_i(en), .is_i(pt[0]), .ie_i(pt[1]), .js_i(pt[2]), .je_i(pt[3]),
    .c_o(c), .n_o(n), .cb_o(cbv), .ca_o(cav)
  );
  spct_dot #(.CB(CB)) u_dot (
    .clk_i, .en_i(en), .cutoff_i(cutoff_q), .c_i(c), .n_i(n), .cb_i(cbv),
    .ca_i(cav), .hit_o(hit)
  );
  assign m_axis_tvalid_o = vld_q[Depth-1];
  assign m_axis_tdata_o = {7'b0, hit};
endmodule

/* tb/testbench.sv */
// testbench for the segment pair cutoff test: directed and random segment pairs checked
// against an exact integer predictor through a scoreboard
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import spct_pkg::*;

  localparam int unsigned CB = 16;
  localparam int unsigned DW = ((12*CB+7)/8)*8;
  localparam int unsigned WatchLimit = 2000;
  localparam int unsigned NumRandom = 1900;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct {
    coord_t p[12];
  } seg_pair_t;

  class range_board;
    logic [CutoffBits-1:0] cutoff = '0;
    bit hit_q[$];
    int errors;
    int checked;
    int hits;

    function automatic bit predict(seg_pair_t sp);
      logic signed [127:0] a[3], b[3], c[3], n[3], cb[3], ca[3];
      logic signed [255:0] d, ns, nt, cn, lhs, rhs;
      for (int k = 0; k < 3; k++) begin
        a[k] = 128'(sp.p[3+k]) - 128'(sp.p[k]);
        b[k] = 128'(sp.p[9+k]) - 128'(sp.p[6+k]);
        c[k] = 128'(sp.p[6+k]) - 128'(sp.p[k]);
      end
      n[0] = a[1]*b[2] - a[2]*b[1];
      n[1] = a[2]*b[0] - a[0]*b[2];
      n[2] = a[0]*b[1] - a[1]*b[0];
      cb[0] = c[1]*b[2] - c[2]*b[1];
      cb[1] = c[2]*b[0] - c[0]*b[2];
      cb[2] = c[0]*b[1] - c[1]*b[0];
      ca[0] = c[1]*a[2] - c[2]*a[1];
      ca[1] = c[2]*a[0] - c[0]*a[2];
      ca[2] = c[0]*a[1] - c[1]*a[0];
      d = 256'(n[0])*n[0] + 256'(n[1])*n[1] + 256'(n[2])*n[2];
      if (d == 0) return 1'b0;
      ns = 256'(cb[0])*n[0] + 256'(cb[1])*n[1] + 256'(cb[2])*n[2];
      nt = 256'(ca[0])*n[0] + 256'(ca[1])*n[1] + 256'(ca[2])*n[2];
      cn = 256'(c[0])*n[0] + 256'(c[1])*n[1] + 256'(c[2])*n[2];
      lhs = cn * cn;
      rhs = $signed({222'd0, cutoff}) * d;
      return ns >= 0 && ns <= d && nt >= 0 && nt <= d && lhs <= rhs;
    endfunction

    function void note_pair(seg_pair_t sp);
      hit_q.push_back(predict(sp));
    endfunction

    function void check_range(logic [7:0] got);
      bit exp_hit;
      checked++;
      if (hit_q.size() == 0) begin
        $error("in_range: no result expected, actual %0d", got[0]);
        errors++;
        return;
      end
      exp_hit = hit_q.pop_front();
      hits += exp_hit;
      if (got[0] !== exp_hit) begin
        $error("in_range: expected %0d actual %0d", exp_hit, got[0]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  // i start xyz, i end xyz, j start xyz, j end xyz
  logic [DW-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  // in_range
  logic [7:0] m_axis_tdata_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrBits+2:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  range_board board = new();
  bit sending_done = 1'b0;
  int unsigned idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  segment_pair_cutoff_test #(.COORD_BITS(CB)) DUT (.*);

  // result side with random stalls
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      board.check_range(m_axis_tdata_o);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
        || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_cutoff(logic [CutoffBits-1:0] val);
    paddr <= {RegCutoff, 3'b000};
    pwdata <= 64'(val);
    pwrite <= 1'b1;
    psel <= 1'b1;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.cutoff = val;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (board.hit_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_pair(seg_pair_t sp, bit no_gap = 1'b0);
    logic [DW-1:0] packed_word;
    int gap;
    packed_word = '0;
    for (int k = 0; k < 12; k++) packed_word[k*CB +: CB] = sp.p[k];
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= packed_word;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_pair(sp);
  endtask

  task automatic stop_sending();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic coord_t rnd_coord(int span);
    if (span >= 32768) return coord_t'($urandom());
    return coord_t'($signed($urandom_range(0, 2*span)) - span);
  endfunction

  // random pair: mostly crossing segments built around a near-common point
  function automatic seg_pair_t rnd_pair(int span);
    seg_pair_t sp;
    coord_t ctr;
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      if (mode < 6) begin
        ctr = rnd_coord(span / 2);
        sp.p[k] = ctr - rnd_coord(span / 2);
        sp.p[3+k] = 2*ctr - sp.p[k] + rnd_coord(2);
        sp.p[6+k] = ctr + rnd_coord(span / 2) + rnd_coord(3);
        sp.p[9+k] = 2*ctr - sp.p[6+k] + rnd_coord(3);
      end else if (mode < 8) begin
        for (int m = 0; m < 4; m++) sp.p[3*m+k] = rnd_coord(span);
      end else begin
        for (int m = 0; m < 4; m++) sp.p[3*m+k] = rnd_coord(32768);
      end
    end
    if (mode == 9) for (int k = 0; k < 3; k++) sp.p[9+k] = sp.p[6+k] + sp.p[3+k] - sp.p[k];
    return sp;
  endfunction

  function automatic seg_pair_t mk(int x0, y0, z0, x1, y1, z1,
                                   int x2, y2, z2, x3, y3, z3);
    seg_pair_t sp;
    int v[12];
    v = '{x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3};
    for (int k = 0; k < 12; k++) sp.p[k] = coord_t'(v[k]);
    return sp;
  endfunction

  localparam logic [CutoffBits-1:0] CutoffMax = '1;

  initial begin
    logic [CutoffBits-1:0] cut_set[5];
    cut_set = '{34'd0, 34'd4, 34'd100, 34'd1000000, CutoffMax};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at reset cutoff of zero, then at cutoff four, then at the maximum cutoff
    send_pair(mk(-10, 0, 0, 10, 0, 0, 0, -10, 0, 0, 10, 0));
    send_pair(mk(-10, 0, 0, 10, 0, 0, 0, -10, 1, 0, 10, 1));
    stop_sending();
    drain();
    write_cutoff(34'd4);
    send_pair(mk(-10, 0, 0, 10, 0, 0, 0, -10, 2, 0, 10, 2), 1);
    send_pair(mk(-10, 0, 0, 10, 0, 0, 0, -10, 3, 0, 10, 3), 1);
    send_pair(mk(0, 0, 0, 10, 0, 0, 0, 5, 1, 10, 5, 1), 1);
    send_pair(mk(0, 0, 0, 0, 0, 0, 0, -5, 0, 0, 5, 0), 1);
    send_pair(mk(0, 0, 0, 10, 0, 0, 20, -5, 0, 20, 5, 0), 1);
    send_pair(mk(0, 0, 0, 10, 0, 0, 5, 3, 0, 5, 13, 0), 1);
    send_pair(mk(0, 0, 0, 10, 0, 0, 10, -5, 0, 10, 5, 0));
    send_pair(mk(0, 0, 0, 10, 0, 0, 0, -5, 0, 0, 5, 0));
    stop_sending();
    drain();
    write_cutoff(CutoffMax);
    send_pair(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                 -32768, 32767, -32768, 32767, -32768, 32767));
    send_pair(mk(-32768, 0, 0, 32767, 0, 0, 0, -32768, 32767, 0, 32767, -32768));
    send_pair(mk(32767, -32768, 0, -32768, 32767, 0, 0, 0, -32768, 0, 0, 32767));
    send_pair(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    send_pair(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                 32767, -32768, 32767, -32768, 32767, -32768));
    stop_sending();
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_cutoff(cut_set[ph]);
      for (int i = 0; i < NumRandom / 5; i++)
        send_pair(rnd_pair((i % 20 == 0) ? 32768 : (ph < 3 ? 40 : 2000)));
      stop_sending();
      drain();
    end
    write_cutoff(34'($urandom()) ^ (34'($urandom_range(0, 3)) << 32));
    for (int i = 0; i < 40; i++) send_pair(rnd_pair(30));
    stop_sending();
    sending_done = 1'b1;
  end

  initial begin
    wait (sending_done);
    while (board.hit_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d segment pairs over six cutoff settings, %0d in range",
             board.checked, board.hits);
    if (board.errors == 0 && board.hit_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
